[rtl/tvdfl_pkg.sv]
// Package for the TVD face flux limiter: widths, limiter codes, face kinds, stage types.
// No dependencies.
package tvdfl_pkg;
    localparam int FRAC_BITS  = 16;
    localparam int VW         = 32;
    localparam int PSI_W      = FRAC_BITS + 3;
    localparam int QB         = FRAC_BITS + 4;
    localparam int MAG_W      = VW + 1;
    localparam int DW         = 2 * MAG_W + 8;
    localparam int XW         = DW + QB + 2;

    typedef enum logic [3:0] {
        LIM_UPWIND = 4'd0, LIM_SUPERBEE = 4'd1, LIM_CHARM = 4'd2, LIM_KOREN = 4'd3,
        LIM_MC = 4'd4, LIM_OSPRE = 4'd5, LIM_SMART = 4'd6, LIM_VANLEER = 4'd7,
        LIM_HCUS = 4'd8, LIM_MINMOD = 4'd9, LIM_HQUICK = 4'd10
    } t_lim;

    localparam logic [1:0] MODE_MINUS = 2'd0;
    localparam logic [1:0] MODE_PLUS  = 2'd1;

    localparam logic [1:0] REG_LIMITER = 2'd0;
    localparam logic [1:0] REG_MINUS   = 2'd1;
    localparam logic [1:0] REG_PLUS    = 2'd2;
    localparam logic [1:0] REG_EMBED   = 2'd3;

    localparam logic [MAG_W+35:0] BIG_RATIO = (MAG_W+36)'(64'd10000000000);

    function automatic logic [PSI_W-1:0] limit_of(input logic [3:0] sel);
        logic [3:0] h;
        case (sel)
            LIM_SUPERBEE, LIM_KOREN, LIM_MC, LIM_VANLEER: h = 4'd4;
            LIM_CHARM, LIM_HCUS: h = 4'd6;
            LIM_OSPRE: h = 4'd3;
            LIM_SMART, LIM_HQUICK: h = 4'd8;
            LIM_MINMOD: h = 4'd2;
            default: h = 4'd0;
        endcase
        return PSI_W'(h) << (FRAC_BITS - 1);
    endfunction

    // a fraction a/b, or a fixed value
    typedef struct packed {
        logic            vld;
        logic            fixed;
        logic [PSI_W-1:0] val;
        logic [DW-1:0]   a;
        logic [DW-1:0]   b;
    } t_frac;
endpackage

[rtl/tvd_face_flux_limiter.sv]
// TVD face flux limiter, one face per cycle.
// Throughput one face per cycle.
// The pipeline is four front stages and the divider pipeline, one quotient bit per stage.
// Reset clears the valid pipeline and the configuration registers; the receiver cannot stall.
// Depends on tvdfl_pkg and tvdfl_divider.
module tvd_face_flux_limiter (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          i_cfg_we,
    input  logic [1:0]                    i_cfg_index,
    input  logic [3:0]                    i_cfg_data,
    input  logic [1:0]                    i_mode,
    input  logic signed [31:0]            i_face_velocity,
    input  logic signed [31:0]            i_far_minus_value,
    input  logic signed [31:0]            i_minus_value,
    input  logic signed [31:0]            i_plus_value,
    input  logic signed [31:0]            i_far_plus_value,
    input  logic                          i_far_minus_blocked,
    input  logic                          i_far_plus_blocked,
    output logic                          o_psi_strobe,
    output logic [18:0]                   o_psi
);
    localparam int MW = tvdfl_pkg::MAG_W;
    localparam int DW = tvdfl_pkg::DW;
    localparam int PW = tvdfl_pkg::PSI_W;
    localparam logic [PW-1:0] ONE = PW'(1) << tvdfl_pkg::FRAC_BITS;

    logic [3:0] r_sel;
    logic       r_mphys, r_pphys, r_emb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sel <= '0; r_mphys <= 1'b0; r_pphys <= 1'b0; r_emb <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                tvdfl_pkg::REG_LIMITER: r_sel <= i_cfg_data;
                tvdfl_pkg::REG_MINUS:   r_mphys <= i_cfg_data[0];
                tvdfl_pkg::REG_PLUS:    r_pphys <= i_cfg_data[0];
                tvdfl_pkg::REG_EMBED:   r_emb <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    assign busy = 1'b0;

    // stage 1: face decision, signed num/den
    logic              n_fixed;
    logic [PW-1:0]     n_val;
    logic signed [MW-1:0] n_num, n_den;
    logic              vpos, vneg;
    always_comb begin
        vpos = !i_face_velocity[31] && (i_face_velocity != '0);
        vneg = i_face_velocity[31];
        n_den = MW'(i_plus_value) - MW'(i_minus_value);
        n_num = vpos ? MW'(i_minus_value) - MW'(i_far_minus_value)
                     : MW'(i_far_plus_value) - MW'(i_plus_value);
        n_fixed = 1'b1;
        n_val = '0;
        if (!vpos && !vneg) begin
            n_val = ONE;
        end else if (i_mode == tvdfl_pkg::MODE_MINUS && vpos) begin
            n_val = r_mphys ? ONE : '0;
        end else if (i_mode == tvdfl_pkg::MODE_PLUS && vneg) begin
            n_val = r_pphys ? ONE : '0;
        end else if (i_mode[1] && r_emb &&
                     ((vpos && i_far_minus_blocked) || (vneg && i_far_plus_blocked))) begin
            n_val = '0;
        end else begin
            n_fixed = 1'b0;
        end
    end

    logic r1_vld, r1_fixed;
    logic [PW-1:0] r1_val;
    logic signed [MW-1:0] r1_num, r1_den;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r1_vld <= 1'b0;
        else          r1_vld <= start;
        r1_fixed <= n_fixed; r1_val <= n_val; r1_num <= n_num; r1_den <= n_den;
    end

    // stage 2: magnitudes, special cases
    logic [MW-1:0] n2_n, n2_d;
    logic          n2_fixed;
    logic [PW-1:0] n2_val, lim;
    always_comb begin
        lim = tvdfl_pkg::limit_of(r_sel);
        n2_n = r1_den[MW-1] ? MW'(-r1_num) : MW'(r1_num);
        n2_d = r1_den[MW-1] ? MW'(-r1_den) : MW'(r1_den);
        n2_fixed = r1_fixed;
        n2_val = r1_val;
        if (!r1_fixed) begin
            if (r1_den == '0) begin
                n2_fixed = 1'b1;
                n2_val = r1_num[MW-1] ? '0 : lim;
            end else if (n2_n[MW-1] || n2_n == '0) begin
                n2_fixed = 1'b1;
                n2_val = '0;
            end
        end
    end

    logic r2_vld, r2_fixed;
    logic [PW-1:0] r2_val;
    logic [MW-1:0] r2_n, r2_d;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r2_vld <= 1'b0;
        else          r2_vld <= r1_vld;
        r2_fixed <= n2_fixed; r2_val <= n2_val; r2_n <= n2_n; r2_d <= n2_d;
    end

    // stage 3: limiter region and fraction terms
    logic [MW+2:0] n3x, d1, d2, d3, d4, d5;
    logic [MW+35:0] big;
    logic [DW-1:0] fa, fb, ma1, ma2, mb1, mb2;
    logic          use_mul;
    logic          n3_fixed;
    logic [PW-1:0] n3_val;
    always_comb begin
        n3x = (MW+3)'(r2_n);
        d1  = (MW+3)'(r2_d);
        d2  = d1 << 1;
        d3  = d2 + d1;
        d4  = d1 << 2;
        d5  = d4 + d1;
        big = (MW+36)'(r2_d) * tvdfl_pkg::BIG_RATIO;
        n3_fixed = r2_fixed;
        n3_val = r2_val;
        fa = '0; fb = DW'(1);
        ma1 = '0; ma2 = '0; mb1 = '0; mb2 = '0;
        use_mul = 1'b0;
        if (!r2_fixed) begin
            if ((MW+36)'(r2_n) >= big) begin
                n3_fixed = 1'b1;
                n3_val = tvdfl_pkg::limit_of(r_sel);
            end else begin
                case (r_sel)
                    tvdfl_pkg::LIM_SUPERBEE: begin
                        if ((n3x << 1) <= d1) begin fa = DW'(n3x << 1); fb = DW'(d1); end
                        else if (n3x <= d1) begin n3_fixed = 1'b1; n3_val = ONE; end
                        else if (n3x <= d2) begin fa = DW'(n3x); fb = DW'(d1); end
                        else begin n3_fixed = 1'b1; n3_val = ONE << 1; end
                    end
                    tvdfl_pkg::LIM_CHARM: begin
                        use_mul = 1'b1;
                        ma1 = DW'(n3x); ma2 = DW'((n3x << 1) + n3x + d1);
                        mb1 = DW'(n3x + d1); mb2 = DW'(n3x + d1);
                    end
                    tvdfl_pkg::LIM_KOREN: begin
                        if ((n3x << 2) + n3x <= d2) begin fa = DW'(n3x << 1); fb = DW'(d1); end
                        else if (n3x >= d4) begin n3_fixed = 1'b1; n3_val = ONE << 1; end
                        else begin fa = DW'(n3x + d2); fb = DW'(d3); end
                    end
                    tvdfl_pkg::LIM_MC: begin
                        if ((n3x << 1) + n3x <= d1) begin fa = DW'(n3x << 1); fb = DW'(d1); end
                        else if (n3x >= d3) begin n3_fixed = 1'b1; n3_val = ONE << 1; end
                        else begin fa = DW'(n3x + d1); fb = DW'(d2); end
                    end
                    tvdfl_pkg::LIM_OSPRE: begin
                        use_mul = 1'b1;
                        ma1 = DW'(n3x); ma2 = DW'(((n3x + d1) << 1) + n3x + d1);
                        mb1 = DW'(n3x + d1); mb2 = DW'(d1);
                    end
                    tvdfl_pkg::LIM_SMART: begin
                        if ((n3x << 2) + n3x <= d1) begin fa = DW'(n3x << 1); fb = DW'(d1); end
                        else if (n3x >= d5) begin n3_fixed = 1'b1; n3_val = ONE << 2; end
                        else begin fa = DW'((n3x << 1) + n3x + d1); fb = DW'(d4); end
                    end
                    tvdfl_pkg::LIM_VANLEER: begin fa = DW'(n3x << 1); fb = DW'(n3x + d1); end
                    tvdfl_pkg::LIM_HCUS: begin fa = DW'((n3x << 1) + n3x); fb = DW'(n3x + d2); end
                    tvdfl_pkg::LIM_MINMOD: begin
                        if (n3x >= d1) begin n3_fixed = 1'b1; n3_val = ONE; end
                        else begin fa = DW'(n3x); fb = DW'(d1); end
                    end
                    tvdfl_pkg::LIM_HQUICK: begin fa = DW'(n3x << 2); fb = DW'(n3x + d3); end
                    default: begin n3_fixed = 1'b1; n3_val = '0; end
                endcase
            end
        end
    end

    logic r3_vld, r3_fixed, r3_mul, r3_osp;
    logic [PW-1:0] r3_val;
    logic [DW-1:0] r3_fa, r3_fb, r3_ma1, r3_ma2, r3_mb1, r3_mb2;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r3_vld <= 1'b0;
        else          r3_vld <= r2_vld;
        r3_fixed <= n3_fixed; r3_val <= n3_val; r3_mul <= use_mul;
        r3_osp <= (r_sel == tvdfl_pkg::LIM_OSPRE);
        r3_fa <= fa; r3_fb <= fb;
        r3_ma1 <= ma1; r3_ma2 <= ma2; r3_mb1 <= mb1; r3_mb2 <= mb2;
    end

    // stage 4: products for the rational limiters
    // charm: a = n(3n+d), b = (n+d)^2; ospre: a = 3n(n+d), b = 2n(n+d) + 2d^2
    localparam int HW = MW + 3;
    logic [DW-1:0] pa, pb, pc;
    assign pa = DW'(r3_ma1[HW-1:0]) * DW'(r3_ma2[HW-1:0]);
    assign pb = DW'(r3_mb2[HW-1:0]) * DW'(r3_mb2[HW-1:0]);
    assign pc = DW'(r3_ma1[HW-1:0]) * DW'(r3_mb1[HW-1:0]);

    logic r4_vld, r4_fixed, r4_mul, r4_osp;
    logic [PW-1:0] r4_val;
    logic [DW-1:0] r4_fa, r4_fb, r4_pa, r4_pb, r4_pc;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r4_vld <= 1'b0;
        else          r4_vld <= r3_vld;
        r4_fixed <= r3_fixed; r4_val <= r3_val; r4_mul <= r3_mul; r4_osp <= r3_osp;
        r4_fa <= r3_fa; r4_fb <= r3_fb; r4_pa <= pa; r4_pb <= pb; r4_pc <= pc;
    end

    tvdfl_pkg::t_frac frac;
    always_comb begin
        frac.vld   = r4_vld;
        frac.fixed = r4_fixed;
        frac.val   = r4_val;
        frac.a     = r4_mul ? r4_pa : r4_fa;
        frac.b     = !r4_mul ? r4_fb : (r4_osp ? (r4_pc << 1) + (r4_pb << 1) : r4_pb);
    end

    tvdfl_divider u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_frac (frac),
        .o_vld  (o_psi_strobe),
        .o_psi  (o_psi)
    );

`ifndef SYNTH
    a_strobe_lat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r4_vld |-> ##(tvdfl_pkg::QB + 1) o_psi_strobe) else $error("strobe lost");
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_psi_strobe |-> o_psi <= (ONE << 2)) else $error("psi out of range");
    a_fixed_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r2_vld && r2_fixed) |=> r3_fixed) else $error("fixed result dropped");
`endif
endmodule

[rtl/tvdfl_divider.sv]
// Pipelined restoring divider: round(a/b * 2^FRAC_BITS), ties up, one quotient bit per stage.
// Depends on tvdfl_pkg.
module tvdfl_divider (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  tvdfl_pkg::t_frac              i_frac,
    output logic                          o_vld,
    output logic [tvdfl_pkg::PSI_W-1:0]   o_psi
);
    localparam int QB = tvdfl_pkg::QB;
    localparam int XW = tvdfl_pkg::XW;
    localparam int DW = tvdfl_pkg::DW;

    logic [QB:0]        r_vld;
    logic [QB:0]        r_fix;
    logic [XW-1:0]      r_x [QB+1];
    logic [DW:0]        r_y [QB+1];
    logic [QB-1:0]      r_q [QB+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[QB-1:0], i_frac.vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r_fix[0] <= i_frac.fixed;
        r_x[0]   <= (XW'(i_frac.a) << (tvdfl_pkg::FRAC_BITS + 1)) + XW'(i_frac.b);
        r_y[0]   <= {i_frac.b, 1'b0};
        r_q[0]   <= QB'(i_frac.val);
    end

    for (genvar s = 0; s < QB; s++) begin : g_st
        localparam int BIT = QB - 1 - s;
        logic [XW-1:0] t;
        logic          le;
        assign t  = XW'(r_y[s]) << BIT;
        assign le = (t <= r_x[s]) && ((XW'(r_y[s]) >> (XW - BIT)) == '0);
        always_ff @(posedge i_clk) begin
            r_fix[s+1] <= r_fix[s];
            r_y[s+1]   <= r_y[s];
            if (!r_fix[s] && le) begin
                r_x[s+1] <= r_x[s] - t;
                r_q[s+1] <= r_q[s] | (QB'(1) << BIT);
            end else begin
                r_x[s+1] <= r_x[s];
                r_q[s+1] <= r_q[s];
            end
        end
    end

    assign o_vld = r_vld[QB];
    assign o_psi = tvdfl_pkg::PSI_W'(r_q[QB]);
endmodule
